// ===== hw/rtl/ifp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifp_pkg - shared types and constants of the IPv4 fragment planner
// Field widths, header constants, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifp_pkg;

    // Stream word widths
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MTU = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL = 4'd1;

    // Header constants
    localparam logic [15:0] HDR_LEN     = 16'd20;
    localparam logic [15:0] MIN_MTU     = 16'd1044;
    localparam logic [15:0] MTU_RESET   = 16'd1500;
    localparam logic [7:0]  TTL_RESET   = 8'd64;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam int          DF_BIT      = 14;
    localparam int          MF_BIT      = 13;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted input word
        logic base;     // fit test, sizes and fixed part of the checksum
        logic plan;     // fields and raw sum of the current packet
        logic emit;     // fold and load the output register
        logic ctr_inc;  // advance the identifier counter
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;     // planned packet is the final one
        logic drop;     // datagram is dropped
        logic out_free; // output register can take a word this cycle
    } t_dp_sts;

endpackage

// ===== hw/rtl/ifp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifp_ctrl - sequencer of the IPv4 fragment planner
// Walks each datagram through latch, base sum, then a plan/emit pair per
// output packet, waiting on the output register when the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifp_ctrl
    import ifp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BASE = 2'd1;
    localparam logic [1:0] ST_PLAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BASE;
                end
            end
            ST_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = ST_PLAN;
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.ctr_inc = i_sts.last & ~i_sts.drop;
                    n_state       = i_sts.last ? ST_IDLE : ST_PLAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A final emit always returns to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (r_state == ST_IDLE))
        else $error("final packet did not return to idle");

    // Planning is always followed by an emit attempt
    a_plan_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.plan |=> (r_state == ST_EMIT))
        else $error("plan not followed by emit");

    // The counter only moves on the final packet of a datagram
    a_ctr_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ctr_inc |-> (o_cmd.emit && i_sts.last))
        else $error("counter advanced mid datagram");

endmodule

// ===== hw/rtl/ifp_datapath.sv =====
// ----------------------------------------------------------------------------
// ifp_datapath - header registers, fragment sizing and checksum
// Holds the configuration, the identifier counter, the latched header,
// the running payload offset and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifp_datapath
    import ifp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input word
    input  logic                  i_in_orig,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_status,
    output logic                  o_out_last,
    // control
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts
);

    // Configuration and counter
    logic [15:0] r_mtu;
    logic [7:0]  r_ttl_cfg;
    logic [12:0] r_ctr;

    // Latched header
    logic [15:0] r_tlen;
    logic [7:0]  r_tos;
    logic [15:0] r_id;
    logic [15:0] r_fo;
    logic [7:0]  r_ttl;
    logic [7:0]  r_proto;
    logic [31:0] r_src;
    logic [31:0] r_dst;

    // Per-datagram plan
    logic        r_fits;
    logic        r_drop;
    logic [15:0] r_plen;
    logic [15:0] r_fsize;
    logic [18:0] r_base;
    logic [15:0] r_off;

    // Current packet
    logic [15:0] r_len;
    logic [15:0] r_w;
    logic [15:0] r_ps;
    logic        r_last;
    logic [19:0] r_raw;

    // Output register
    logic        r_out_valid;
    logic        r_out_drop;
    logic        r_out_last;
    logic [15:0] r_out_id;
    logic [15:0] r_out_fo;
    logic [15:0] r_out_len;
    logic [15:0] r_out_ps;
    logic [15:0] r_out_sum;

    logic [15:0] w_m;
    logic [18:0] w_base;
    logic [16:0] w_off_end;
    logic        w_is_last;
    logic [12:0] w_off8;
    logic [15:0] p_len;
    logic [15:0] p_w;
    logic [15:0] p_ps;
    logic        p_last;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;
    logic        w_out_free;

    // Effective mtu, clamped from below
    assign w_m = (r_mtu < MIN_MTU) ? MIN_MTU : r_mtu;

    // Fixed words of the header: version/tos, id, ttl/proto, addresses
    assign w_base = {3'd0, VER_IHL, r_tos} + {3'd0, r_id} + {3'd0, r_ttl, r_proto}
                  + {3'd0, r_src[31:16]} + {3'd0, r_src[15:0]}
                  + {3'd0, r_dst[31:16]} + {3'd0, r_dst[15:0]};

    // Fragment fields at the current offset
    assign w_off_end = {1'b0, r_off} + {1'b0, r_fsize};
    assign w_is_last = (w_off_end >= {1'b0, r_plen});
    assign w_off8    = r_fo[12:0] + r_off[15:3];

    always_comb begin
        priority if (r_fits) begin
            p_len  = r_tlen;
            p_w    = r_fo;
            p_ps   = 16'd0;
            p_last = 1'b1;
        end else if (r_drop) begin
            p_len  = 16'd0;
            p_w    = 16'd0;
            p_ps   = 16'd0;
            p_last = 1'b1;
        end else begin
            p_len  = (w_is_last ? (r_plen - r_off) : r_fsize) + HDR_LEN;
            p_w    = {r_fo[15:14], r_fo[MF_BIT] | ~w_is_last, w_off8};
            p_ps   = r_off;
            p_last = w_is_last;
        end
    end

    // End-around carry fold of the raw sum
    assign w_fold1 = {1'b0, r_raw[15:0]} + {13'd0, r_raw[19:16]};
    assign w_fold2 = w_fold1[15:0] + {15'd0, w_fold1[16]};

    assign w_out_free = ~r_out_valid | i_out_ready;

    // Configuration, counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu       <= MTU_RESET;
            r_ttl_cfg   <= TTL_RESET;
            r_ctr       <= 13'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MTU: r_mtu     <= i_cfg_data;
                    CFG_TTL: r_ttl_cfg <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.ctr_inc) begin
                r_ctr <= r_ctr + 13'd1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // latch the input word, building the header for local traffic
        if (i_cmd.load) begin
            r_tlen <= i_in_data[15:0];
            r_src  <= i_in_data[103:72];
            r_dst  <= i_in_data[135:104];
            if (i_in_orig) begin
                r_tos   <= 8'd0;
                r_id    <= {3'd0, r_ctr};
                r_fo    <= 16'd0;
                r_ttl   <= r_ttl_cfg;
                r_proto <= PROTO_TCP;
            end else begin
                r_tos   <= i_in_data[23:16];
                r_id    <= i_in_data[39:24];
                r_fo    <= i_in_data[55:40];
                r_ttl   <= i_in_data[63:56];
                r_proto <= i_in_data[71:64];
            end
        end
        // fit test and fragment size
        if (i_cmd.base) begin
            r_fits  <= (r_tlen <= w_m);
            r_drop  <= (r_tlen > w_m) & r_fo[DF_BIT];
            r_plen  <= r_tlen - HDR_LEN;
            r_fsize <= (w_m - HDR_LEN) & 16'hfff8;
            r_base  <= w_base;
            r_off   <= 16'd0;
        end
        // one packet's fields and its unfolded sum
        if (i_cmd.plan) begin
            r_len  <= p_len;
            r_w    <= p_w;
            r_ps   <= p_ps;
            r_last <= p_last;
            r_raw  <= {1'b0, r_base} + {4'd0, p_len} + {4'd0, p_w};
        end
        // output word
        if (i_cmd.emit) begin
            r_off      <= w_off_end[15:0];
            r_out_drop <= r_drop;
            r_out_last <= r_last;
            if (r_drop) begin
                r_out_id  <= 16'd0;
                r_out_fo  <= 16'd0;
                r_out_len <= 16'd0;
                r_out_ps  <= 16'd0;
                r_out_sum <= 16'd0;
            end else begin
                r_out_id  <= r_id;
                r_out_fo  <= r_w;
                r_out_len <= r_len;
                r_out_ps  <= r_ps;
                r_out_sum <= ~w_fold2;
            end
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.drop     = r_drop;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_drop;
    assign o_out_last   = r_out_last;
    assign o_out_data   = {r_out_sum, r_out_ps, r_out_len, r_out_fo, r_out_id};

    // An emit never overwrites a word that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

    // A drop word is always the final one
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_drop) |-> r_out_last)
        else $error("drop word without last");

    // Non-final fragments carry MF and a full fragment length
    a_mid_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |->
        (r_out_fo[MF_BIT] && (r_out_len == r_fsize + HDR_LEN)))
        else $error("bad non-final fragment");

endmodule

// ===== hw/rtl/ipv4_fragment_planner.sv =====
// ----------------------------------------------------------------------------
// ipv4_fragment_planner - plans outgoing IPv4 headers and fragments
// Usage:
//   Slave stream: one word per datagram. tuser is the originate flag; tdata
//   carries the header fields. Locally originated datagrams get TOS 0,
//   protocol 6, the configured TTL and the next 13-bit identifier.
//   Master stream: one word per emitted header, or one drop word (tuser=1)
//   when DF is set and the datagram exceeds the mtu. tlast marks the final
//   word of a datagram.
//   Config channel: index 0 mtu, index 1 default TTL; always ready. Write
//   only while the block is idle.
// Sequence:
//   An accepted datagram is latched, then a base step does the fit test,
//   sizes and fixed part of the checksum; each output packet (up to 64)
//   then takes a plan/emit pair through one checksum adder and fold. The
//   next datagram is accepted once the final word is registered, while
//   that word may still wait at the output.
//   A stall on the master side holds the output register and the sequencer.
// Reset: synchronous active low; mtu 1500, TTL 64, identifier counter 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_fragment_planner
    import ifp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // datagram descriptors
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata, low bit up: total_len[15:0], tos[23:16], ident[39:24],
    // flags_offset[55:40], hop_limit[63:56], protocol[71:64],
    // src_addr[103:72], dst_addr[135:104]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: originate
    input  logic                  i_s_tuser,
    // planned headers
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata, low bit up: out_ident[15:0], out_flags_offset[31:16],
    // frag_len[47:32], payload_start[63:48], header_sum[79:64]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // tuser: status
    output logic                  o_m_tuser,
    output logic                  o_m_tlast,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ifp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ifp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_orig    (i_s_tuser),
        .i_in_data    (i_s_tdata),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_data   (o_m_tdata),
        .o_out_status (o_m_tuser),
        .o_out_last   (o_m_tlast),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the IPv4 fragment planner
// Streams datagram descriptors into the planner under several link settings
// and checks every header word against a local model of the fit test,
// fragment sizing, flag/offset rules, identifier counter and header checksum.
// A short directed table comes first, then constrained-by-hand random traffic
// with random stalls on both streams and one long output back-pressure window.
// ----------------------------------------------------------------------------

module tb_top;
    import ifp_pkg::*;

    localparam int WDOG_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int HOLD_AT     = 150;   // datagram count that starts the long stall
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LO    = 250;   // no random idling in this item window
    localparam int QUIET_HI    = 330;
    localparam int PHASE_ITEMS = 70;

    // one datagram descriptor
    typedef struct packed {
        logic        originate;
        logic [15:0] total_len;
        logic [7:0]  tos;
        logic [15:0] ident;
        logic [15:0] flags_offset;
        logic [7:0]  hop_limit;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_dgram;

    // one planned header word
    typedef struct packed {
        logic        status;
        logic [15:0] ident;
        logic [15:0] flags_offset;
        logic [15:0] frag_len;
        logic [15:0] payload_start;
        logic [15:0] header_sum;
        logic        last;
    } t_hdr;

    typedef enum logic [1:0] {ROW_SEND, ROW_TYPED, ROW_LINK} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_dgram      dg;
        t_hdr        hdr;
        logic [15:0] mtu;
        logic [7:0]  ttl;
    } t_row;

    // DUT connections; the driven inputs are all known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic                  s_tuser    = 1'b0;
    logic                  m_tready   = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;
    logic                  o_cfg_ready;

    // model state
    logic [15:0] link_mtu = MTU_RESET;
    logic [7:0]  link_ttl = TTL_RESET;
    logic [12:0] ident_ctr = '0;
    t_hdr        hdr_expect_q[$];

    int n_fail    = 0;
    int n_dgrams  = 0;
    int n_frag    = 0;
    int n_drop    = 0;
    int n_words   = 0;
    int n_links   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int wdog      = 0;

    ipv4_fragment_planner i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock, 20 ns period
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // random idling, off inside the quiet window
    function automatic bit take_break();
        if (n_dgrams >= QUIET_LO && n_dgrams < QUIET_HI)
            return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    // ones-complement sum over the ten big-endian header words
    function automatic logic [15:0] hdr_csum(logic [7:0] tos, logic [15:0] len,
                                             logic [15:0] id, logic [15:0] fo,
                                             logic [7:0] ttl, logic [7:0] proto,
                                             logic [31:0] src, logic [31:0] dst);
        int unsigned s;
        s = {VER_IHL, tos} + len + id + fo + {ttl, proto}
            + src[31:16] + src[15:0] + dst[31:16] + dst[15:0];
        while (s >> 16)
            s = (s & 32'hffff) + (s >> 16);
        return ~s[15:0];
    endfunction

    // expected header words of one accepted datagram
    task automatic plan_headers(input t_dgram d);
        logic [7:0]  tos, ttl, proto;
        logic [15:0] id, fo, w;
        int unsigned m, plen, fsize, off, chunk, len;
        int          k;
        bit          fin;
        t_hdr        h;
        m = 32'((link_mtu < MIN_MTU) ? MIN_MTU : link_mtu);
        if (d.originate) begin
            tos   = 8'h00;
            id    = {3'b000, ident_ctr};
            fo    = 16'h0000;
            ttl   = link_ttl;
            proto = PROTO_TCP;
        end else begin
            tos   = d.tos;
            id    = d.ident;
            fo    = d.flags_offset;
            ttl   = d.hop_limit;
            proto = d.protocol;
        end
        n_dgrams++;
        if (d.total_len <= m) begin
            h = '{1'b0, id, fo, d.total_len, 16'h0000,
                  hdr_csum(tos, d.total_len, id, fo, ttl, proto,
                           d.src_addr, d.dst_addr), 1'b1};
            hdr_expect_q.push_back(h);
            ident_ctr++;
        end else if (fo[DF_BIT]) begin
            hdr_expect_q.push_back('{1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1});
            n_drop++;
        end else begin
            // 8-byte aligned chunks; reserved/DF kept, MF sticky, offset wraps
            plen  = 32'(d.total_len) - 32'(HDR_LEN);
            fsize = (m - 32'(HDR_LEN)) & ~32'd7;
            off   = 0;
            k     = 0;
            while (off < plen && k < 64) begin
                fin   = (off + fsize >= plen);
                chunk = fin ? (plen - off) : fsize;
                len   = chunk + 32'(HDR_LEN);
                w     = (fo & 16'hc000) | (fo & 16'h2000)
                        | ((fo[12:0] + off[15:3]) & 16'h1fff);
                if (!fin)
                    w[MF_BIT] = 1'b1;
                h = '{1'b0, id, w, len[15:0], off[15:0],
                      hdr_csum(tos, len[15:0], id, w, ttl, proto,
                               d.src_addr, d.dst_addr), fin};
                hdr_expect_q.push_back(h);
                k++;
                off += fsize;
            end
            ident_ctr++;
            n_frag++;
        end
    endtask

    function automatic t_dgram mk_dg(logic orig, logic [15:0] len, logic [7:0] tos,
                                     logic [15:0] id, logic [15:0] fo,
                                     logic [7:0] hl, logic [7:0] proto,
                                     logic [31:0] src, logic [31:0] dst);
        return '{orig, len, tos, id, fo, hl, proto, src, dst};
    endfunction

    function automatic t_row row_send(t_dgram d);
        return '{ROW_SEND, d, '0, 16'h0, 8'h0};
    endfunction

    function automatic t_row row_typed(t_dgram d, t_hdr h);
        return '{ROW_TYPED, d, h, 16'h0, 8'h0};
    endfunction

    function automatic t_row row_link(logic [15:0] mtu, logic [7:0] ttl);
        return '{ROW_LINK, '0, '0, mtu, ttl};
    endfunction

    // random descriptor biased around the current effective mtu
    function automatic t_dgram rand_dgram();
        t_dgram      d;
        int unsigned m, r, hi;
        m = 32'((link_mtu < MIN_MTU) ? MIN_MTU : link_mtu);
        d.originate    = 1'($urandom_range(1));
        d.tos          = 8'($urandom);
        d.ident        = 16'($urandom);
        d.flags_offset = 16'($urandom);
        d.hop_limit    = 8'($urandom);
        d.protocol     = 8'($urandom);
        d.src_addr     = $urandom;
        d.dst_addr     = $urandom;
        if ($urandom_range(99) < 60)
            d.flags_offset[DF_BIT] = 1'b0;
        if ($urandom_range(99) < 15)
            d.flags_offset[12:0] = 13'(32'h1fff - $urandom_range(40));
        r  = $urandom_range(99);
        hi = (3 * m > 65535) ? 65535 : 3 * m;
        if (r < 8 || m >= 65535)
            d.total_len = 16'((r < 8) ? $urandom_range(19) : $urandom);
        else if (r < 45)
            d.total_len = 16'($urandom_range(m, HDR_LEN));
        else if (r < 80)
            d.total_len = 16'($urandom_range(hi, m + 1));
        else
            d.total_len = 16'($urandom_range(65535, m + 1));
        return d;
    endfunction

    // offer one descriptor; tvalid stays high after the accepting edge
    task automatic send_dgram(input t_dgram d, input bit typed, input t_hdr th);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= d.originate;
        s_tdata  <= {d.dst_addr, d.src_addr, d.protocol, d.hop_limit,
                     d.flags_offset, d.ident, d.tos, d.total_len};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        plan_headers(d);
        if (typed) begin
            void'(hdr_expect_q.pop_back());
            hdr_expect_q.push_back(th);
        end
    endtask

    // drain, then let the sequencer settle
    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        while (hdr_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // write both link registers back to back
    task automatic set_link(input logic [15:0] mtu, input logic [7:0] ttl);
        wait_drained(4);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MTU;
        cfg_data  <= mtu;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        link_mtu  = mtu;
        cfg_index <= CFG_TTL;
        cfg_data  <= {8'h00, ttl};
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        link_ttl  = ttl;
        cfg_valid <= 1'b0;
        n_links++;
    endtask

    function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            n_fail++;
            if (n_fail <= 40)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // output monitor: every accepted word against the oldest expectation
    always @(posedge i_clk) begin : hdr_monitor
        t_hdr want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            n_words++;
            if (hdr_expect_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 40)
                    $display("%0t: unexpected word, expected none, actual %h/%b/%b",
                             $time, o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                want = hdr_expect_q.pop_front();
                field_check("status", 16'(want.status), 16'(o_m_tuser));
                field_check("ident", want.ident, o_m_tdata[15:0]);
                field_check("flags_offset", want.flags_offset, o_m_tdata[31:16]);
                field_check("frag_len", want.frag_len, o_m_tdata[47:32]);
                field_check("payload_start", want.payload_start, o_m_tdata[63:48]);
                field_check("header_sum", want.header_sum, o_m_tdata[79:64]);
                field_check("last", 16'(want.last), 16'(o_m_tlast));
            end
        end
    end

    // output ready: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_dgrams >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= !take_break();
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || (cfg_valid && o_cfg_ready)
            || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        t_row        dir_tab[$];
        t_row        row;
        logic [15:0] ph_mtu[6];
        logic [7:0]  ph_ttl[6];
        ph_mtu = '{16'd1500, 16'd65535, 16'd0, 16'd1044, 16'd576, 16'd0};
        ph_ttl = '{8'd64, 8'd255, 8'd0, 8'd1, 8'd200, 8'd0};

        // reset values, extremes, drops, short length, exact fits
        dir_tab.push_back(row_typed(mk_dg(1, 16'd20, 0, 0, 0, 0, 0, 0, 0),
                          '{1'b0, 16'h0, 16'h0, 16'd20, 16'h0, 16'h7ae5, 1'b1}));
        dir_tab.push_back(row_typed(mk_dg(0, 16'd0, 0, 0, 0, 0, 0, 0, 0),
                          '{1'b0, 16'h0, 16'h0, 16'd0, 16'h0, 16'hbaff, 1'b1}));
        dir_tab.push_back(row_typed(mk_dg(0, 16'hffff, 0, 0, 16'h4000, 0, 0, 0, 0),
                          '{1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1}));
        dir_tab.push_back(row_typed(mk_dg(0, 16'hffff, 8'hff, 16'hffff, 16'hffff, 8'hff,
                                          8'hff, 32'hffffffff, 32'hffffffff),
                          '{1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1}));
        dir_tab.push_back(row_send(mk_dg(0, 16'hffff, 8'hff, 16'hffff, 16'hbfff, 8'hff,
                                         8'hff, 32'hffffffff, 32'hffffffff)));
        dir_tab.push_back(row_send(mk_dg(1, 16'd1500, 8'h11, 16'h2222, 16'h4000, 8'h33,
                                         8'h44, 32'hc0a80001, 32'h0a000001)));
        dir_tab.push_back(row_send(mk_dg(1, 16'd1501, 0, 0, 0, 0, 0,
                                         32'hc0a80001, 32'h0a000001)));
        dir_tab.push_back(row_send(mk_dg(1, 16'd19, 0, 0, 0, 0, 0, 32'h1, 32'h2)));
        dir_tab.push_back(row_send(mk_dg(1, 16'hffff, 0, 0, 0, 0, 0,
                                         32'hffffffff, 32'hffffffff)));
        dir_tab.push_back(row_send(mk_dg(0, 16'd3000, 8'h10, 16'h1234, 16'h2000, 8'd9,
                                         8'd17, 32'h7f000001, 32'h08080808)));
        dir_tab.push_back(row_send(mk_dg(0, 16'd9000, 8'h00, 16'hbeef, 16'h1ff0, 8'd1,
                                         8'd1, 32'h01020304, 32'h05060708)));
        dir_tab.push_back(row_send(mk_dg(0, 16'd2980, 8'h00, 16'h0001, 16'h0000, 8'd128,
                                         8'd6, 32'h0a0a0a0a, 32'h0b0b0b0b)));
        dir_tab.push_back(row_link(16'hffff, 8'hff));
        dir_tab.push_back(row_send(mk_dg(1, 16'hffff, 0, 0, 0, 0, 0, 32'h1, 32'h1)));
        dir_tab.push_back(row_send(mk_dg(0, 16'hffff, 8'h5a, 16'h5a5a, 16'h4000, 8'd7,
                                         8'd50, 32'h12345678, 32'h9abcdef0)));
        // mtu under the floor acts as the floor
        dir_tab.push_back(row_link(16'h0000, 8'h00));
        dir_tab.push_back(row_send(mk_dg(1, 16'hffff, 0, 0, 0, 0, 0,
                                         32'haaaaaaaa, 32'h55555555)));
        dir_tab.push_back(row_typed(mk_dg(0, 16'd1045, 8'h01, 16'h0101, 16'h4000, 8'd2,
                                          8'd3, 32'h4, 32'h5),
                          '{1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1}));
        dir_tab.push_back(row_send(mk_dg(0, 16'd1044, 8'h02, 16'h0202, 16'h0000, 8'd3,
                                         8'd4, 32'h6, 32'h7)));
        dir_tab.push_back(row_link(16'd1044, 8'd128));
        dir_tab.push_back(row_send(mk_dg(0, 16'd2000, 8'h03, 16'h0303, 16'h8000, 8'd4,
                                         8'd5, 32'h8, 32'h9)));
        dir_tab.push_back(row_send(mk_dg(1, 16'd1045, 0, 0, 0, 0, 0, 32'ha, 32'hb)));
        dir_tab.push_back(row_link(MTU_RESET, TTL_RESET));
        dir_tab.push_back(row_send(mk_dg(0, 16'd20, 8'h5a, 16'ha5a5, 16'h0000, 8'd64,
                                         8'd1, 32'hdeadbeef, 32'hfeedface)));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_LINK)
                set_link(row.mtu, row.ttl);
            else
                send_dgram(row.dg, row.kind == ROW_TYPED, row.hdr);
        end

        // random traffic, one link setting per phase
        for (int p = 0; p < 6; p++) begin
            if (p == 5)
                set_link(16'($urandom_range(9000, 1044)), 8'($urandom_range(255)));
            else
                set_link(ph_mtu[p], ph_ttl[p]);
            repeat (PHASE_ITEMS) send_dgram(rand_dgram(), 1'b0, '0);
        end

        wait_drained(16);
        $display("tb: %0d datagrams over %0d link settings: %0d fragmented, %0d dropped",
                 n_dgrams, n_links, n_frag, n_drop);
        $display("tb: %0d header words checked, %0d mismatches", n_words, n_fail);
        if (n_fail == 0 && hdr_expect_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
